// ----- hdl/sky_alloc_pkg.sv -----
package sky_alloc_pkg;

    // request dimensions are 6-bit texel counts
    localparam int unsigned DIM_W       = 6;
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 24;
    localparam int unsigned OUT_TUSER_W = 1;
    localparam int unsigned POS_W       = 8;

    typedef struct packed {
        logic clear;
        logic take;
        logic page_start;
        logic next_page;
        logic bwd_issue;
        logic fwd_start;
        logic fwd_issue;
        logic write_start;
        logic write_issue;
        logic load_result;
        logic result_full;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic zero_dim;
        logic j_zero;
        logic j_last;
        logic fits;
        logic last_page;
        logic k_zero;
        logic out_busy;
    } t_dp_status;

endpackage

// ----- hdl/sky_alloc_ctrl.sv -----
module sky_alloc_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    output sky_alloc_pkg::t_dp_cmd   o_cmd,
    input  sky_alloc_pkg::t_dp_status i_status
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_BWD,
        S_BWD_DRAIN,
        S_FWD,
        S_FWD_DRAIN,
        S_DECIDE,
        S_WRITE,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_fail;
    logic   n_fail;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_fail  = r_fail;
        o_cmd   = '0;
        o_cmd.result_full = r_fail;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.zero_dim) begin
                    n_fail  = 1'b1;
                    n_state = S_RESULT;
                end else begin
                    o_cmd.page_start = 1'b1;
                    n_state          = S_BWD;
                end
            end
            S_BWD: begin
                o_cmd.bwd_issue = 1'b1;
                if (i_status.j_zero) begin
                    n_state = S_BWD_DRAIN;
                end
            end
            S_BWD_DRAIN: begin
                o_cmd.fwd_start = 1'b1;
                n_state         = S_FWD;
            end
            S_FWD: begin
                o_cmd.fwd_issue = 1'b1;
                if (i_status.j_last) begin
                    n_state = S_FWD_DRAIN;
                end
            end
            S_FWD_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_status.fits) begin
                    o_cmd.write_start = 1'b1;
                    n_fail            = 1'b0;
                    n_state           = S_WRITE;
                end else if (i_status.last_page) begin
                    n_fail  = 1'b1;
                    n_state = S_RESULT;
                end else begin
                    // try the next page from scratch
                    o_cmd.next_page  = 1'b1;
                    o_cmd.page_start = 1'b1;
                    n_state          = S_BWD;
                end
            end
            S_WRITE: begin
                o_cmd.write_issue = 1'b1;
                if (i_status.k_zero) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!i_status.out_busy) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_fail  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fail  <= n_fail;
        end
    end

endmodule

// ----- hdl/sky_alloc_dp.sv -----
module sky_alloc_dp #(
    parameter int PAGES   = 2,
    parameter int COLUMNS = 256,
    parameter int ROWS    = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  sky_alloc_pkg::t_dp_cmd                 i_cmd,
    output sky_alloc_pkg::t_dp_status              o_status,
    input  logic [sky_alloc_pkg::IN_TDATA_W-1:0]   i_in_data,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic [sky_alloc_pkg::OUT_TDATA_W-1:0]  o_out_data,
    output logic [sky_alloc_pkg::OUT_TUSER_W-1:0]  o_out_user
);

    localparam int DW    = sky_alloc_pkg::DIM_W;
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int AW    = $clog2(PAGES * COLUMNS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int HW    = $clog2(ROWS + 1);
    localparam int DEPTH = PAGES * COLUMNS;

    localparam logic [CW-1:0] J_LAST    = CW'(COLUMNS - 2);
    localparam logic [AW-1:0] CLR_LAST  = AW'(DEPTH - 1);
    localparam logic [PW-1:0] PAGE_LAST = PW'(PAGES - 1);
    localparam logic [HW:0]   ROWS_X    = (HW + 1)'(ROWS);

    logic [HW-1:0] col_mem [DEPTH];
    logic [HW-1:0] s_mem   [COLUMNS];

    logic [DW-1:0] r_w;
    logic [DW-1:0] r_h;
    logic [PW-1:0] r_page;
    logic [AW-1:0] r_base;
    logic [CW-1:0] r_j;
    logic [CW-1:0] r_j1;
    logic [DW-1:0] r_k;
    logic [DW-1:0] r_d;
    logic [AW-1:0] r_clr;
    logic          r_vb;
    logic          r_vf;
    logic [HW-1:0] r_run;
    logic [HW-1:0] r_best;
    logic [CW-1:0] r_best_x;
    logic          r_found;
    logic [HW-1:0] r_col_q;
    logic [HW-1:0] r_s_q;
    logic          r_out_valid;
    logic [sky_alloc_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic [sky_alloc_pkg::OUT_TUSER_W-1:0] r_out_user;

    logic [CW-1:0] w_m1;
    logic [DW-1:0] d_m1;
    logic [AW-1:0] col_addr;
    logic          col_we;
    logic [AW-1:0] col_waddr;
    logic [HW-1:0] col_wdata;
    logic [CW-1:0] s_raddr;
    logic [HW:0]   top_sum;
    logic [HW-1:0] s_val;
    logic [HW-1:0] p_val;
    logic [HW-1:0] win;
    logic          win_ok;
    logic [31:0]   x_ext;
    logic [31:0]   y_ext;
    logic [sky_alloc_pkg::OUT_TDATA_W-1:0] res_data;

    assign w_m1      = CW'(r_w) - CW'(1);
    assign d_m1      = r_w - DW'(1);
    assign col_addr  = r_base + AW'(r_j);
    assign top_sum   = {1'b0, r_best} + (HW + 1)'(r_h);
    assign col_we    = i_cmd.clear | i_cmd.write_issue;
    assign col_waddr = i_cmd.clear ? r_clr : col_addr;
    assign col_wdata = i_cmd.clear ? '0 : top_sum[HW-1:0];
    assign s_raddr   = r_j - w_m1;

    // suffix max toward the end of the current block
    assign s_val = ((r_d == '0) || (r_col_q > r_run)) ? r_col_q : r_run;
    // prefix max from the start of the current block
    assign p_val = ((r_j1 == '0) || (r_d == d_m1) || (r_col_q > r_run)) ? r_col_q : r_run;
    assign win    = (r_s_q > p_val) ? r_s_q : p_val;
    assign win_ok = (r_j1 >= w_m1);

    assign x_ext = 32'(r_best_x);
    assign y_ext = 32'(r_best);

    always_comb begin
        res_data = '0;
        if (!i_cmd.result_full) begin
            res_data[0]                   = r_page[0];
            res_data[sky_alloc_pkg::POS_W:1] = x_ext[sky_alloc_pkg::POS_W-1:0];
            res_data[2*sky_alloc_pkg::POS_W:sky_alloc_pkg::POS_W+1] =
                y_ext[sky_alloc_pkg::POS_W-1:0];
        end
    end

    always_comb begin
        o_status.clr_last  = (r_clr == CLR_LAST);
        o_status.zero_dim  = (r_w == '0) || (r_h == '0);
        o_status.j_zero    = (r_j == '0);
        o_status.j_last    = (r_j == J_LAST);
        o_status.fits      = r_found && (top_sum <= ROWS_X);
        o_status.last_page = (r_page == PAGE_LAST);
        o_status.k_zero    = (r_k == '0);
        o_status.out_busy  = r_out_valid & ~i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (col_we) begin
            col_mem[col_waddr] <= col_wdata;
        end
        r_col_q <= col_mem[col_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_vb) begin
            s_mem[r_j1] <= s_val;
        end
        r_s_q <= s_mem[s_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_vb        <= 1'b0;
            r_vf        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr <= r_clr + AW'(1);
            end
            r_vb <= i_cmd.bwd_issue;
            r_vf <= i_cmd.fwd_issue;
            if (i_cmd.load_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_w    <= i_in_data[DW-1:0];
            r_h    <= i_in_data[2*DW-1:DW];
            r_page <= '0;
            r_base <= '0;
        end
        if (i_cmd.next_page) begin
            r_page <= r_page + PW'(1);
            r_base <= r_base + AW'(COLUMNS);
        end
        if (i_cmd.page_start) begin
            r_j     <= J_LAST;
            r_d     <= '0;
            r_best  <= HW'(ROWS);
            r_found <= 1'b0;
        end
        if (i_cmd.bwd_issue) begin
            r_j  <= r_j - CW'(1);
            r_j1 <= r_j;
        end
        if (i_cmd.fwd_start) begin
            r_j <= '0;
        end
        if (i_cmd.fwd_issue) begin
            r_j  <= r_j + CW'(1);
            r_j1 <= r_j;
        end
        if (i_cmd.write_start) begin
            r_j <= r_best_x;
            r_k <= d_m1;
        end
        if (i_cmd.write_issue) begin
            r_j <= r_j + CW'(1);
            r_k <= r_k - DW'(1);
        end
        if (r_vb) begin
            r_run <= s_val;
            // hold the phase at column zero for the forward pass
            if (r_j1 != '0) begin
                r_d <= (r_d == d_m1) ? '0 : r_d + DW'(1);
            end
        end
        if (r_vf) begin
            r_run <= p_val;
            r_d   <= (r_d == '0) ? d_m1 : r_d - DW'(1);
            if (win_ok && (win < r_best)) begin
                r_best   <= win;
                r_best_x <= r_j1 - w_m1;
                r_found  <= 1'b1;
            end
        end
        if (i_cmd.load_result) begin
            r_out_data <= res_data;
            r_out_user <= sky_alloc_pkg::OUT_TUSER_W'(i_cmd.result_full);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;

endmodule

// ----- hdl/skyline_atlas_allocator_unit.sv -----
// Channel   Dir  tdata (low bit up)                       tuser
// s_axis    in   block_width[5:0] block_height[11:6]      -
// m_axis    out  page_index[0] x_pos[8:1] y_pos[16:9]     atlas_full[0]
//
// One request at a time. Each page tried runs a backward pass for block suffix
// maxima and a forward pass for prefix and window maxima, both one column per
// cycle through the skyline memory read port; a placement then writes
// block_width columns of the skyline memory.
// After reset the skyline memory is zeroed; tready stays low meanwhile.
// A finished result waits in the output register while the next request is taken.
module skyline_atlas_allocator_unit #(
    parameter int PAGES   = 2,
    parameter int COLUMNS = 256,
    parameter int ROWS    = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // block_width[5:0], block_height[11:6]
    input  logic [sky_alloc_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // page_index[0], x_pos[8:1], y_pos[16:9]
    output logic [sky_alloc_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // atlas_full[0]
    output logic [sky_alloc_pkg::OUT_TUSER_W-1:0]  o_m_axis_tuser
);

    sky_alloc_pkg::t_dp_cmd    cmd;
    sky_alloc_pkg::t_dp_status status;

    sky_alloc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    sky_alloc_dp #(
        .PAGES   (PAGES),
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .o_out_user  (o_m_axis_tuser)
    );

endmodule

// ----- hdl/sky_alloc_checker.sv -----
module sky_alloc_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_s_axis_tvalid,
    input logic                                   o_s_axis_tready,
    input logic [sky_alloc_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    input logic                                   o_m_axis_tvalid,
    input logic                                   i_m_axis_tready,
    input logic [sky_alloc_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input logic [sky_alloc_pkg::OUT_TUSER_W-1:0]  o_m_axis_tuser
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_pend;
    logic [1:0] n_pend;

    assign in_acc  = i_s_axis_tvalid & o_s_axis_tready;
    assign out_acc = o_m_axis_tvalid & i_m_axis_tready;

    // requests taken whose result has not been delivered yet
    always_comb begin
        n_pend = r_pend;
        if (in_acc && !out_acc) begin
            n_pend = r_pend + 2'd1;
        end else if (out_acc && !in_acc) begin
            n_pend = r_pend - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata == '0)
        else $error("full result carries a placement");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> r_pend != 2'd0)
        else $error("result without a pending request");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> r_pend <= 2'd1)
        else $error("request taken while another is still in work");

    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("ready before skyline clear finished");

endmodule

bind skyline_atlas_allocator_unit sky_alloc_checker u_sky_alloc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
